### rtl/core/dvam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drum voice allocator and mixer: shared definitions
// Field widths, action and result codes, controller states and the
// control word that drives the mix accumulator.
// ----------------------------------------------------------------------------
package dvam_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ADDR_W     = 16;
    localparam int LEN_IN_W   = 17;
    localparam int VOICE_IN_W = 3;
    localparam int SLOT_OUT_W = 2;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_SET_LEN = 2'd1,
        ACT_TRIGGER = 2'd2,
        ACT_TICK    = 2'd3
    } action_t;

    typedef enum logic {
        KIND_MIX     = 1'b0,
        KIND_TRIGGER = 1'b1
    } result_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SET_LEN,
        ST_SCAN,
        ST_DRAIN,
        ST_TRIG_WR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clear;
        logic add;
    } mix_ctl_t;

endpackage
`default_nettype wire

### rtl/core/dvam_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dvam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### rtl/core/dvam_mix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drum voice allocator and mixer: mix accumulator
// Sums the slot samples of one tick and saturates the total to 16 bits.
// ----------------------------------------------------------------------------
module dvam_mix #(
    parameter int NUM_SLOTS = 24
) (
    input  wire logic                                  aclk,
    input  wire dvam_pkg::mix_ctl_t                    ctl,
    input  wire logic signed [dvam_pkg::SAMPLE_W-1:0]  sample,
    output logic signed      [dvam_pkg::SAMPLE_W-1:0]  mixed_sample,
    output logic                                       clipped
);
    import dvam_pkg::*;

    localparam int ACC_W = SAMPLE_W + $clog2(NUM_SLOTS + 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    always_comb begin
        acc_next = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (ctl.add) begin
            acc_next = acc_reg + ACC_W'(sample);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    always_comb begin
        if (acc_reg > SAT_HI) begin
            mixed_sample = SAMPLE_W'(SAT_HI);
            clipped      = 1'b1;
        end else if (acc_reg < SAT_LO) begin
            mixed_sample = SAMPLE_W'(SAT_LO);
            clipped      = 1'b1;
        end else begin
            mixed_sample = SAMPLE_W'(acc_reg);
            clipped      = 1'b0;
        end
    end

endmodule
`default_nettype wire

### rtl/core/drum_voice_allocator_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drum voice allocator and mixer
// Polyphonic drum sample player: sample memory per voice, a fixed pool of
// playback slots per voice with stealing, and a saturating mix on each tick.
//
//   channel | direction | ports                                        | moves
//   s_      | in        | action, voice_index, word_address,           | one word
//           |           | word_value, sample_length                    | per item
//   m_      | out       | result_kind, mixed_sample, clipped,          | one word
//           |           | chosen_slot, stolen                          | per result
//
// A load or set-length passes through a single write state; a trigger scans the
// slots of its voice and a tick scans every slot of every voice: the slot
// memory read port visits one slot per cycle. One item is in work at a time.
// Reset clears the voice lengths and the slot valid bits at once; there is no
// clearing pass, and sample memory holds nothing until it is loaded.
// A new word is taken while a finished result still waits on a stalled m_ side.
// ----------------------------------------------------------------------------
module drum_voice_allocator_mixer #(
    parameter int NUM_VOICES      = 6,
    parameter int SLOTS_PER_VOICE = 4,
    parameter int MAX_SAMPLE_LEN  = 65536
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [1:0]                             s_action,
    input  wire logic [dvam_pkg::VOICE_IN_W-1:0]        s_voice_index,
    input  wire logic [dvam_pkg::ADDR_W-1:0]            s_word_address,
    input  wire logic signed [dvam_pkg::SAMPLE_W-1:0]   s_word_value,
    input  wire logic [dvam_pkg::LEN_IN_W-1:0]          s_sample_length,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic                                        m_result_kind,
    output logic signed [dvam_pkg::SAMPLE_W-1:0]        m_mixed_sample,
    output logic                                        m_clipped,
    output logic [dvam_pkg::SLOT_OUT_W-1:0]             m_chosen_slot,
    output logic                                        m_stolen
);
    import dvam_pkg::*;

    localparam int NUM_SLOTS  = NUM_VOICES * SLOTS_PER_VOICE;
    localparam int SLOT_AW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SUB_W      = (SLOTS_PER_VOICE > 1) ? $clog2(SLOTS_PER_VOICE) : 1;
    localparam int VOICE_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CUR_W      = $clog2(MAX_SAMPLE_LEN);
    localparam int LEN_W      = $clog2(MAX_SAMPLE_LEN + 1);
    localparam int SLOT_DW    = CUR_W + 1;
    localparam int SMEM_DEPTH = NUM_VOICES * MAX_SAMPLE_LEN;
    localparam int SMEM_AW    = $clog2(SMEM_DEPTH);

    localparam logic [SUB_W-1:0]   LAST_SUB   = SUB_W'(SLOTS_PER_VOICE - 1);
    localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(NUM_VOICES - 1);
    localparam logic [LEN_W-1:0]   MAX_LEN    = LEN_W'(MAX_SAMPLE_LEN);
    localparam logic [SMEM_AW-1:0] REGION     = SMEM_AW'(MAX_SAMPLE_LEN);
    localparam logic [SLOT_AW-1:0] VOICE_SPAN = SLOT_AW'(SLOTS_PER_VOICE);

    state_t state_reg;
    state_t state_next;

    logic s_fire;
    logic voice_ok;
    logic addr_ok;
    logic [LEN_W-1:0] len_sat;
    logic [VOICE_W-1:0] in_voice;

    logic tick_reg;
    logic [VOICE_W-1:0] voice_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic [LEN_W-1:0] len_reg;

    logic [SLOT_AW-1:0] rd_idx_reg;
    logic [SUB_W-1:0] rd_sub_reg;
    logic [VOICE_W-1:0] rd_voice_reg;
    logic scan_last;

    logic p1_valid_reg;
    logic [SLOT_AW-1:0] p1_idx_reg;
    logic [SUB_W-1:0] p1_sub_reg;
    logic [VOICE_W-1:0] p1_voice_reg;
    logic p2_valid_reg;

    logic found_reg;
    logic [SUB_W-1:0] pick_sub_reg;
    logic [SLOT_AW-1:0] pick_idx_reg;
    logic [CUR_W-1:0] best_cur_reg;

    logic [NUM_SLOTS-1:0] slot_vld_reg;
    logic [LEN_W-1:0] voice_len_reg [NUM_VOICES];

    logic m_valid_reg;
    result_kind_t m_kind_reg;
    logic signed [SAMPLE_W-1:0] m_mix_reg;
    logic m_clip_reg;
    logic [SLOT_OUT_W-1:0] m_slot_reg;
    logic m_stolen_reg;

    logic scan_rd;
    logic smem_we;
    logic len_we;
    logic trig_wr;
    logic out_load;
    logic out_free;
    mix_ctl_t mix_ctl;

    logic [SLOT_DW-1:0] slot_rd_data;
    logic slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    logic [SLOT_DW-1:0] slot_wdata;

    logic p1_act;
    logic [CUR_W-1:0] p1_cur;
    logic [LEN_W-1:0] p1_len;
    logic [LEN_W-1:0] p1_cur_ext;
    logic [LEN_W-1:0] p1_adv;
    logic p1_live;
    logic p1_play;

    logic [SMEM_AW-1:0] smem_waddr;
    logic [SMEM_AW-1:0] smem_raddr;
    logic signed [SAMPLE_W-1:0] smem_rd_data;
    logic signed [SAMPLE_W-1:0] mix_sample;
    logic mix_clip;

    assign s_fire   = s_valid && s_ready;
    assign in_voice = VOICE_W'(s_voice_index);
    assign voice_ok = 32'(s_voice_index) < 32'(NUM_VOICES);
    assign addr_ok  = 32'(s_word_address) < 32'(MAX_SAMPLE_LEN);
    assign len_sat  = (32'(s_sample_length) > 32'(MAX_SAMPLE_LEN)) ? MAX_LEN
                                                                    : LEN_W'(s_sample_length);
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_last = (rd_sub_reg == LAST_SUB) && (!tick_reg || rd_voice_reg == LAST_VOICE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_action)
                        ACT_LOAD: begin
                            if (voice_ok && addr_ok) begin
                                state_next = ST_LOAD;
                            end
                        end
                        ACT_SET_LEN: begin
                            if (voice_ok) begin
                                state_next = ST_SET_LEN;
                            end
                        end
                        ACT_TRIGGER: begin
                            if (voice_ok) begin
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_TICK: begin
                            state_next = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD:    state_next = ST_IDLE;
            ST_SET_LEN: state_next = ST_IDLE;
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!p1_valid_reg && !p2_valid_reg) begin
                    state_next = tick_reg ? ST_RESULT : ST_TRIG_WR;
                end
            end
            ST_TRIG_WR: state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        smem_we       = (state_reg == ST_LOAD);
        len_we        = (state_reg == ST_SET_LEN);
        scan_rd       = (state_reg == ST_SCAN);
        trig_wr       = (state_reg == ST_TRIG_WR);
        out_load      = (state_reg == ST_RESULT) && out_free;
        mix_ctl.clear = (state_reg == ST_IDLE);
        mix_ctl.add   = p2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Slot state seen by the first pipeline stage; a slot never written since
    // the last length change reads as free with its cursor at zero.
    always_comb begin
        p1_act     = slot_vld_reg[p1_idx_reg] & slot_rd_data[CUR_W];
        p1_cur     = slot_vld_reg[p1_idx_reg] ? slot_rd_data[CUR_W-1:0] : '0;
        p1_len     = voice_len_reg[p1_voice_reg];
        p1_cur_ext = LEN_W'(p1_cur);
        p1_adv     = p1_cur_ext + LEN_W'(1);
        p1_live    = p1_valid_reg && tick_reg && (p1_len != '0) && p1_act;
        p1_play    = p1_live && (p1_cur_ext < p1_len);
    end

    always_comb begin
        if (trig_wr) begin
            slot_we    = 1'b1;
            slot_waddr = pick_idx_reg;
            slot_wdata = {1'b1, {CUR_W{1'b0}}};
        end else begin
            slot_we    = p1_live;
            slot_waddr = p1_idx_reg;
            if (p1_play && (p1_adv < p1_len)) begin
                slot_wdata = {1'b1, CUR_W'(p1_adv)};
            end else begin
                slot_wdata = '0;
            end
        end
    end

    assign smem_waddr = SMEM_AW'(voice_reg) * REGION + SMEM_AW'(addr_reg);
    assign smem_raddr = SMEM_AW'(p1_voice_reg) * REGION + SMEM_AW'(p1_cur);

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            tick_reg  <= (s_action == ACT_TICK);
            voice_reg <= in_voice;
            addr_reg  <= s_word_address;
            value_reg <= s_word_value;
            len_reg   <= len_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_sub_reg <= '0;
            if (s_action == ACT_TICK) begin
                rd_idx_reg   <= '0;
                rd_voice_reg <= '0;
            end else begin
                rd_idx_reg   <= SLOT_AW'(in_voice) * VOICE_SPAN;
                rd_voice_reg <= in_voice;
            end
        end else if (scan_rd) begin
            rd_idx_reg <= rd_idx_reg + SLOT_AW'(1);
            if (rd_sub_reg == LAST_SUB) begin
                rd_sub_reg   <= '0;
                rd_voice_reg <= rd_voice_reg + VOICE_W'(1);
            end else begin
                rd_sub_reg <= rd_sub_reg + SUB_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= scan_rd;
            p2_valid_reg <= p1_play;
        end
    end

    always_ff @(posedge aclk) begin
        p1_idx_reg   <= rd_idx_reg;
        p1_sub_reg   <= rd_sub_reg;
        p1_voice_reg <= rd_voice_reg;
    end

    // Trigger choice: the first free slot wins; with none free, the largest
    // cursor wins and the lowest slot takes a tie.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            found_reg    <= 1'b0;
            pick_sub_reg <= '0;
            pick_idx_reg <= '0;
            best_cur_reg <= '0;
        end else if (p1_valid_reg && !tick_reg && !found_reg) begin
            if (!p1_act) begin
                found_reg    <= 1'b1;
                pick_sub_reg <= p1_sub_reg;
                pick_idx_reg <= p1_idx_reg;
            end else if ((p1_sub_reg == '0) || (p1_cur > best_cur_reg)) begin
                pick_sub_reg <= p1_sub_reg;
                pick_idx_reg <= p1_idx_reg;
                best_cur_reg <= p1_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_vld_reg <= '0;
            for (int v = 0; v < NUM_VOICES; v++) begin
                voice_len_reg[v] <= '0;
            end
        end else begin
            if (len_we) begin
                slot_vld_reg             <= '0;
                voice_len_reg[voice_reg] <= len_reg;
            end else if (slot_we) begin
                slot_vld_reg[slot_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (tick_reg) begin
                m_kind_reg   <= KIND_MIX;
                m_mix_reg    <= mix_sample;
                m_clip_reg   <= mix_clip;
                m_slot_reg   <= '0;
                m_stolen_reg <= 1'b0;
            end else begin
                m_kind_reg   <= KIND_TRIGGER;
                m_mix_reg    <= '0;
                m_clip_reg   <= 1'b0;
                m_slot_reg   <= SLOT_OUT_W'(pick_sub_reg);
                m_stolen_reg <= !found_reg;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_mixed_sample = m_mix_reg;
    assign m_clipped      = m_clip_reg;
    assign m_chosen_slot  = m_slot_reg;
    assign m_stolen       = m_stolen_reg;

    dvam_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SMEM_DEPTH)
    ) u_sample_ram (
        .clk     (aclk),
        .wr_en   (smem_we),
        .wr_addr (smem_waddr),
        .wr_data (value_reg),
        .rd_addr (smem_raddr),
        .rd_data (smem_rd_data)
    );

    dvam_ram #(
        .WIDTH (SLOT_DW),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk     (aclk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data (slot_wdata),
        .rd_addr (rd_idx_reg),
        .rd_data (slot_rd_data)
    );

    dvam_mix #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_mix (
        .aclk         (aclk),
        .ctl          (mix_ctl),
        .sample       (smem_rd_data),
        .mixed_sample (mix_sample),
        .clipped      (mix_clip)
    );

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!p1_valid_reg && !p2_valid_reg))
        else $error("slot pipeline still busy when a new word can be taken");

    a_slot_rw_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_we && scan_rd) |-> (slot_waddr != rd_idx_reg))
        else $error("slot write collides with the slot read in flight");

    a_sample_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_valid_reg |-> tick_reg)
        else $error("sample read issued outside a tick");

    a_trigger_pick_in_voice: assert property (@(posedge aclk) disable iff (!aresetn)
        trig_wr |-> (pick_idx_reg == SLOT_AW'(voice_reg) * VOICE_SPAN + SLOT_AW'(pick_sub_reg)))
        else $error("trigger slot lies outside the addressed voice");

endmodule
`default_nettype wire

### tb/tb_drum_voice_allocator_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the drum voice allocator and mixer
// Sends load, set-length, trigger and tick words with random gaps, keeps its
// own copy of sample memory, voice lengths and slot cursors to predict every
// trigger report and mix, and checks each result word field by field while
// the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_drum_voice_allocator_mixer;

    import dvam_pkg::*;

    localparam int NUM_VOICES      = 6;
    localparam int SLOTS_PER_VOICE = 4;
    localparam int MAX_LEN         = 65536;
    localparam int NUM_SLOTS       = NUM_VOICES * SLOTS_PER_VOICE;
    localparam int RANDOM_ITEMS    = 1750;
    localparam int DRAIN_CYCLES    = 60;
    localparam int STALL_LIMIT     = 1000;

    typedef struct {
        result_kind_t       kind;
        logic signed [15:0] mix;
        logic               clip;
        logic [1:0]         slot;
        logic               stolen;
    } player_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [1:0]                    s_action;
    logic [VOICE_IN_W-1:0]         s_voice_index;
    logic [ADDR_W-1:0]             s_word_address;
    logic signed [SAMPLE_W-1:0]    s_word_value;
    logic [LEN_IN_W-1:0]           s_sample_length;
    logic                          m_valid;
    logic                          m_ready;
    logic                          m_result_kind;
    logic signed [SAMPLE_W-1:0]    m_mixed_sample;
    logic                          m_clipped;
    logic [SLOT_OUT_W-1:0]         m_chosen_slot;
    logic                          m_stolen;

    logic [15:0]    voice_mem [NUM_VOICES * MAX_LEN];
    bit             word_loaded [NUM_VOICES * MAX_LEN];
    int             voice_len [NUM_VOICES];
    bit             slot_busy [NUM_SLOTS];
    int             slot_pos [NUM_SLOTS];
    player_result_t awaited_results[$];
    player_result_t oldest;

    int useful_items;
    int results_seen;
    int error_count;
    int idle_cycles;
    int send_calm;
    int recv_calm;

    drum_voice_allocator_mixer #(
        .NUM_VOICES     (NUM_VOICES),
        .SLOTS_PER_VOICE(SLOTS_PER_VOICE),
        .MAX_SAMPLE_LEN (MAX_LEN)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_voice_index  (s_voice_index),
        .s_word_address (s_word_address),
        .s_word_value   (s_word_value),
        .s_sample_length(s_sample_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_mixed_sample (m_mixed_sample),
        .m_clipped      (m_clipped),
        .m_chosen_slot  (m_chosen_slot),
        .m_stolen       (m_stolen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [15:0] draw_sample();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) begin
            return 16'h7FFF;
        end else if (roll == 1) begin
            return 16'h8000;
        end
        return 16'($urandom);
    endfunction

    function automatic void advance_player(action_t act, logic [2:0] voice, logic [15:0] addr,
                                           logic [15:0] value, logic [16:0] len);
        player_result_t r;
        int             vi;
        int             base;
        int             pick;
        int             sum;
        int             cur;
        int             k;
        bit             found;
        vi = int'(voice);
        r = '{KIND_MIX, 16'sd0, 1'b0, 2'd0, 1'b0};
        case (act)
            ACT_LOAD: begin
                if (vi < NUM_VOICES) begin
                    voice_mem[vi * MAX_LEN + int'(addr)] = value;
                    word_loaded[vi * MAX_LEN + int'(addr)] = 1'b1;
                    useful_items++;
                end
            end
            ACT_SET_LEN: begin
                if (vi < NUM_VOICES) begin
                    voice_len[vi] = (int'(len) > MAX_LEN) ? MAX_LEN : int'(len);
                    for (int s = 0; s < NUM_SLOTS; s++) begin
                        slot_busy[s] = 1'b0;
                        slot_pos[s] = 0;
                    end
                    useful_items++;
                end
            end
            ACT_TRIGGER: begin
                if (vi < NUM_VOICES) begin
                    base = vi * SLOTS_PER_VOICE;
                    pick = 0;
                    found = 1'b0;
                    for (int s = 0; s < SLOTS_PER_VOICE; s++) begin
                        if (!found && !slot_busy[base + s]) begin
                            pick = s;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        for (int s = 1; s < SLOTS_PER_VOICE; s++) begin
                            if (slot_pos[base + s] > slot_pos[base + pick]) pick = s;
                        end
                    end
                    slot_busy[base + pick] = 1'b1;
                    slot_pos[base + pick] = 0;
                    r.kind = KIND_TRIGGER;
                    r.slot = pick[1:0];
                    r.stolen = !found;
                    awaited_results.push_back(r);
                    useful_items++;
                end
            end
            ACT_TICK: begin
                sum = 0;
                for (int v = 0; v < NUM_VOICES; v++) begin
                    if (voice_len[v] == 0) continue;
                    for (int s = 0; s < SLOTS_PER_VOICE; s++) begin
                        k = v * SLOTS_PER_VOICE + s;
                        if (!slot_busy[k]) continue;
                        cur = slot_pos[k];
                        if (cur >= voice_len[v]) begin
                            slot_busy[k] = 1'b0;
                            slot_pos[k] = 0;
                            continue;
                        end
                        sum += int'($signed(voice_mem[v * MAX_LEN + cur]));
                        cur++;
                        if (cur >= voice_len[v]) begin
                            slot_busy[k] = 1'b0;
                            cur = 0;
                        end
                        slot_pos[k] = cur;
                    end
                end
                if (sum > 32767) begin
                    sum = 32767;
                    r.clip = 1'b1;
                end else if (sum < -32768) begin
                    sum = -32768;
                    r.clip = 1'b1;
                end
                r.mix = sum[15:0];
                awaited_results.push_back(r);
                useful_items++;
            end
        endcase
    endfunction

    task automatic send_word(action_t act, logic [2:0] voice, logic [15:0] addr,
                             logic [15:0] value, logic [16:0] len);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_action        <= act;
        s_voice_index   <= voice;
        s_word_address  <= addr;
        s_word_value    <= value;
        s_sample_length <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_player(act, voice, addr, value, len);
    endtask

    task automatic load_word(int voice, int addr, logic [15:0] value);
        send_word(ACT_LOAD, voice[2:0], addr[15:0], value, 17'($urandom));
    endtask

    task automatic set_length(int voice, int len);
        send_word(ACT_SET_LEN, voice[2:0], 16'($urandom), 16'($urandom), len[16:0]);
    endtask

    task automatic trigger_voice(int voice);
        send_word(ACT_TRIGGER, voice[2:0], 16'($urandom), 16'($urandom), 17'($urandom));
    endtask

    // Every word that the next tick will read is loaded first.
    task automatic tick_mix();
        int k;
        int addr;
        for (int v = 0; v < NUM_VOICES; v++) begin
            for (int s = 0; s < SLOTS_PER_VOICE; s++) begin
                k = v * SLOTS_PER_VOICE + s;
                addr = slot_pos[k];
                if (voice_len[v] != 0 && slot_busy[k] && addr < voice_len[v]
                        && !word_loaded[v * MAX_LEN + addr]) begin
                    load_word(v, addr, draw_sample());
                end
            end
        end
        send_word(ACT_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 17'($urandom));
    endtask

    task automatic report_mismatch(string field, int got, int want);
        error_count++;
        if (error_count <= 100) begin
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     results_seen, field, got, want);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected word of kind", int'(m_result_kind), -1);
            end else begin
                oldest = awaited_results.pop_front();
                if (m_result_kind !== oldest.kind)
                    report_mismatch("result_kind", int'(m_result_kind), int'(oldest.kind));
                if (m_mixed_sample !== oldest.mix)
                    report_mismatch("mixed_sample", int'(m_mixed_sample), int'(oldest.mix));
                if (m_clipped !== oldest.clip)
                    report_mismatch("clipped", int'(m_clipped), int'(oldest.clip));
                if (m_chosen_slot !== oldest.slot)
                    report_mismatch("chosen_slot", int'(m_chosen_slot), int'(oldest.slot));
                if (m_stolen !== oldest.stolen)
                    report_mismatch("stolen", int'(m_stolen), int'(oldest.stolen));
            end
        end
    end

    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = draw_gap(recv_calm);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_reset_state();
        tick_mix();
    endtask

    task automatic test_ignored_words();
        set_length(0, 2);
        trigger_voice(0);
        set_length(6, 131071);
        load_word(7, 65535, 16'h8000);
        trigger_voice(7);
        trigger_voice(6);
        tick_mix();
    endtask

    task automatic test_clipping();
        load_word(0, 0, 16'h7FFF);
        load_word(1, 0, 16'h7FFF);
        load_word(2, 0, 16'h8000);
        set_length(0, 1);
        set_length(1, 1);
        set_length(2, 1);
        trigger_voice(0);
        trigger_voice(0);
        trigger_voice(1);
        tick_mix();
        trigger_voice(2);
        tick_mix();
        trigger_voice(2);
        trigger_voice(2);
        tick_mix();
    endtask

    task automatic test_stealing();
        set_length(0, 8);
        trigger_voice(0);
        tick_mix();
        trigger_voice(0);
        tick_mix();
        trigger_voice(0);
        trigger_voice(0);
        trigger_voice(0);
        tick_mix();
        trigger_voice(0);
    endtask

    task automatic test_silent_and_long_voices();
        set_length(3, 131071);
        set_length(4, 65535);
        set_length(4, 65536);
        set_length(5, 0);
        repeat (5) trigger_voice(5);
        trigger_voice(3);
        trigger_voice(4);
        tick_mix();
        tick_mix();
    endtask

    task automatic test_random_sessions();
        int roll;
        int len;
        int steps;
        while (useful_items < RANDOM_ITEMS) begin
            for (int v = 0; v < NUM_VOICES + 2; v++) begin
                if ((v < NUM_VOICES && $urandom_range(0, 3) != 0) || $urandom_range(0, 7) == 0) begin
                    roll = $urandom_range(0, 19);
                    if (roll == 0) len = 0;
                    else if (roll == 1) len = MAX_LEN;
                    else if (roll == 2) len = $urandom_range(MAX_LEN + 1, 131071);
                    else if (roll == 3) len = $urandom_range(0, 131071);
                    else len = $urandom_range(1, 40);
                    set_length(v, len);
                end
            end
            steps = $urandom_range(20, 80);
            repeat (steps) begin
                roll = $urandom_range(0, 99);
                if (roll < 42) begin
                    tick_mix();
                end else if (roll < 78) begin
                    if ($urandom_range(0, 9) == 0) trigger_voice($urandom_range(6, 7));
                    else trigger_voice($urandom_range(0, NUM_VOICES - 1));
                end else if (roll < 90) begin
                    load_word($urandom_range(0, 7),
                              ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) : $urandom,
                              draw_sample());
                end else if (roll < 93) begin
                    set_length($urandom_range(0, 7), $urandom_range(0, 131071));
                end else begin
                    trigger_voice($urandom_range(0, NUM_VOICES - 1));
                end
            end
        end
    endtask

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_action        <= ACT_LOAD;
        s_voice_index   <= '0;
        s_word_address  <= '0;
        s_word_value    <= '0;
        s_sample_length <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_ignored_words();
        test_clipping();
        test_stealing();
        test_silent_and_long_voices();
        test_random_sessions();

        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/dvam_pkg.sv
rtl/core/dvam_ram.sv
rtl/core/dvam_mix.sv
rtl/core/drum_voice_allocator_mixer.sv
tb/tb_drum_voice_allocator_mixer.sv
